[rtl/i2cbr_pkg.sv]
// Package for the I2C bus-clear recovery sequencer.
// Holds the item, result and configuration types, the status codes, the phase encoding and the register constants.
// No dependencies.
`default_nettype none

package i2cbr_pkg;

    localparam int STARTUP_W  = 24;
    localparam int HALF_W     = 10;
    localparam int POLL_INT_W = 24;
    localparam int LIMIT_W    = 6;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_WAIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PULSE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT    = 3'd4;

    localparam logic [STARTUP_W-1:0]  RST_STARTUP_WAIT  = 24'd2500000;
    localparam logic [HALF_W-1:0]     RST_HALF_PULSE    = 10'd10;
    localparam logic [POLL_INT_W-1:0] RST_POLL_INTERVAL = 24'd100000;
    localparam logic [LIMIT_W-1:0]    RST_PULSE_LIMIT   = 6'd20;
    localparam logic [LIMIT_W-1:0]    RST_POLL_LIMIT    = 6'd20;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SCL_LOW  = 2'd1;
    localparam logic [1:0] ST_STRETCH  = 2'd2;
    localparam logic [1:0] ST_SDA_LOW  = 2'd3;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_STARTUP    = 7'b0000010,
        PH_PULSE_LOW  = 7'b0000100,
        PH_PULSE_HIGH = 7'b0001000,
        PH_POLL       = 7'b0010000,
        PH_START_LOW  = 7'b0100000,
        PH_STOP_WAIT  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic op;
        logic scl_level;
        logic sda_level;
    } item_t;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       pullups_on;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } res_t;

    typedef struct packed {
        logic [STARTUP_W-1:0]  startup_wait_ticks;
        logic [HALF_W-1:0]     half_pulse_ticks;
        logic [POLL_INT_W-1:0] poll_interval_ticks;
        logic [LIMIT_W-1:0]    pulse_limit;
        logic [LIMIT_W-1:0]    poll_limit;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/i2cbr_if.sv]
// Valid/ready channel interfaces for sequencer requests and results.
// Depends on i2cbr_pkg.
`default_nettype none

interface i2cbr_item_if;
    logic            valid;
    logic            ready;
    i2cbr_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2cbr_res_if;
    logic            valid;
    logic            ready;
    i2cbr_pkg::res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/i2cbr_cfg.sv]
// Configuration register file of the recovery sequencer.
// Depends on i2cbr_pkg.
`default_nettype none

module i2cbr_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [i2cbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [i2cbr_pkg::CFG_DATA_W-1:0] cfg_data,
    output i2cbr_pkg::cfg_t                       cfg
);

    i2cbr_pkg::cfg_t cfg_reg;
    i2cbr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                i2cbr_pkg::CFG_STARTUP_WAIT:
                    cfg_next.startup_wait_ticks = cfg_data[i2cbr_pkg::STARTUP_W-1:0];
                i2cbr_pkg::CFG_HALF_PULSE:
                    cfg_next.half_pulse_ticks = cfg_data[i2cbr_pkg::HALF_W-1:0];
                i2cbr_pkg::CFG_POLL_INTERVAL:
                    cfg_next.poll_interval_ticks = cfg_data[i2cbr_pkg::POLL_INT_W-1:0];
                i2cbr_pkg::CFG_PULSE_LIMIT:
                    cfg_next.pulse_limit = cfg_data[i2cbr_pkg::LIMIT_W-1:0];
                i2cbr_pkg::CFG_POLL_LIMIT:
                    cfg_next.poll_limit = cfg_data[i2cbr_pkg::LIMIT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.startup_wait_ticks  <= i2cbr_pkg::RST_STARTUP_WAIT;
            cfg_reg.half_pulse_ticks    <= i2cbr_pkg::RST_HALF_PULSE;
            cfg_reg.poll_interval_ticks <= i2cbr_pkg::RST_POLL_INTERVAL;
            cfg_reg.pulse_limit         <= i2cbr_pkg::RST_PULSE_LIMIT;
            cfg_reg.poll_limit          <= i2cbr_pkg::RST_POLL_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/i2cbr_core.sv]
// Recovery state machine: phase, delay timer, pulse and poll counters, line drives.
// Advances one step per request and presents the result of that step.
// Depends on i2cbr_pkg.
`default_nettype none

module i2cbr_core #(
    parameter int TIMER_WIDTH = 24
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire i2cbr_pkg::item_t item,
    input  wire i2cbr_pkg::cfg_t  cfg,
    output i2cbr_pkg::res_t       res
);

    localparam int LW = i2cbr_pkg::LIMIT_W;

    i2cbr_pkg::phase_t       phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0]  wait_reg, wait_next;
    logic [LW-1:0]           pulses_reg, pulses_next;
    logic [LW-1:0]           polls_reg, polls_next;
    logic [1:0]              status_reg, status_next;
    logic                    drv_scl_reg, drv_scl_next;
    logic                    drv_sda_reg, drv_sda_next;
    logic                    drv_pull_reg, drv_pull_next;
    logic                    running;
    logic                    check_sda;
    logic                    fin;
    logic [1:0]              fin_code;

    always_comb
    begin
        phase_next    = phase_reg;
        wait_next     = wait_reg;
        pulses_next   = pulses_reg;
        polls_next    = polls_reg;
        status_next   = status_reg;
        drv_scl_next  = drv_scl_reg;
        drv_sda_next  = drv_sda_reg;
        drv_pull_next = drv_pull_reg;
        running       = 1'b0;
        check_sda     = 1'b0;
        fin           = 1'b0;
        fin_code      = i2cbr_pkg::ST_OK;

        unique case (phase_reg)
            i2cbr_pkg::PH_STARTUP, i2cbr_pkg::PH_PULSE_LOW, i2cbr_pkg::PH_PULSE_HIGH,
            i2cbr_pkg::PH_POLL, i2cbr_pkg::PH_START_LOW, i2cbr_pkg::PH_STOP_WAIT:
                running = 1'b1;
            default:
            begin
                phase_next = i2cbr_pkg::PH_IDLE;
                if (item.op)
                begin
                    drv_scl_next  = 1'b0;
                    drv_sda_next  = 1'b0;
                    drv_pull_next = 1'b1;
                    wait_next     = TIMER_WIDTH'(cfg.startup_wait_ticks);
                    pulses_next   = cfg.pulse_limit;
                    polls_next    = cfg.poll_limit;
                    phase_next    = i2cbr_pkg::PH_STARTUP;
                end
            end
        endcase

        if (running && !item.op)
        begin
            if (wait_reg != '0)
            begin
                wait_next = wait_reg - TIMER_WIDTH'(1);
            end
            else
            begin
                unique case (phase_reg)
                    i2cbr_pkg::PH_STARTUP:
                    begin
                        if (!item.scl_level)
                        begin
                            fin      = 1'b1;
                            fin_code = i2cbr_pkg::ST_SCL_LOW;
                        end
                        else
                        begin
                            check_sda = 1'b1;
                        end
                    end
                    i2cbr_pkg::PH_PULSE_LOW:
                    begin
                        drv_scl_next = 1'b0;
                        wait_next    = TIMER_WIDTH'(cfg.half_pulse_ticks);
                        phase_next   = i2cbr_pkg::PH_PULSE_HIGH;
                    end
                    i2cbr_pkg::PH_PULSE_HIGH, i2cbr_pkg::PH_POLL:
                    begin
                        if (item.scl_level)
                        begin
                            check_sda = 1'b1;
                        end
                        else if (polls_reg != '0)
                        begin
                            polls_next = polls_reg - LW'(1);
                            wait_next  = TIMER_WIDTH'(cfg.poll_interval_ticks);
                            phase_next = i2cbr_pkg::PH_POLL;
                        end
                        else
                        begin
                            fin      = 1'b1;
                            fin_code = i2cbr_pkg::ST_STRETCH;
                        end
                    end
                    i2cbr_pkg::PH_START_LOW:
                    begin
                        drv_sda_next = 1'b0;
                        wait_next    = TIMER_WIDTH'(cfg.half_pulse_ticks);
                        phase_next   = i2cbr_pkg::PH_STOP_WAIT;
                    end
                    default:
                    begin
                        drv_pull_next = 1'b0;
                        fin           = 1'b1;
                        fin_code      = i2cbr_pkg::ST_OK;
                    end
                endcase
            end
        end

        if (check_sda)
        begin
            if (item.sda_level)
            begin
                drv_scl_next = 1'b0;
                drv_sda_next = 1'b1;
                wait_next    = TIMER_WIDTH'(cfg.half_pulse_ticks);
                phase_next   = i2cbr_pkg::PH_START_LOW;
            end
            else if (pulses_reg != '0)
            begin
                pulses_next  = pulses_reg - LW'(1);
                drv_scl_next = 1'b1;
                drv_sda_next = 1'b0;
                wait_next    = TIMER_WIDTH'(cfg.half_pulse_ticks);
                polls_next   = cfg.poll_limit;
                phase_next   = i2cbr_pkg::PH_PULSE_LOW;
            end
            else
            begin
                fin      = 1'b1;
                fin_code = i2cbr_pkg::ST_SDA_LOW;
            end
        end

        if (fin)
        begin
            status_next  = fin_code;
            phase_next   = i2cbr_pkg::PH_IDLE;
            drv_scl_next = 1'b0;
            drv_sda_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= i2cbr_pkg::PH_IDLE;
            wait_reg     <= '0;
            pulses_reg   <= '0;
            polls_reg    <= '0;
            status_reg   <= i2cbr_pkg::ST_OK;
            drv_scl_reg  <= 1'b0;
            drv_sda_reg  <= 1'b0;
            drv_pull_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            wait_reg     <= wait_next;
            pulses_reg   <= pulses_next;
            polls_reg    <= polls_next;
            status_reg   <= status_next;
            drv_scl_reg  <= drv_scl_next;
            drv_sda_reg  <= drv_sda_next;
            drv_pull_reg <= drv_pull_next;
        end
    end

    assign res.scl_drive_low = drv_scl_next;
    assign res.sda_drive_low = drv_sda_next;
    assign res.pullups_on    = drv_pull_next;
    assign res.busy_res      = (phase_next != i2cbr_pkg::PH_IDLE);
    assign res.done_res      = fin;
    assign res.status        = status_next;

endmodule

`default_nettype wire

[rtl/i2c_bus_recovery_sequencer.sv]
// I2C bus-clear recovery sequencer, top level: request register, step core,
// result register and configuration registers.
// Depends on i2cbr_pkg, i2cbr_if, i2cbr_cfg and i2cbr_core.
//
// One request (a tick carrying the sampled SCL/SDA levels, or a start) is taken
// per clock, and each yields exactly one result: the request is held in the
// request register, the step is made as it loads the result register, and the
// result is then offered from there. Throughput is one request per cycle while
// results are taken. A result waiting in the output register holds the step, and
// once the request register is full new requests wait too. A start while a
// sequence runs is ignored. Delays are counted in ticks from the configuration
// registers, and the final status stays on the status field until the next
// sequence ends. Write configuration only while no request is in flight.
`default_nettype none

module i2c_bus_recovery_sequencer #(
    parameter int TIMER_WIDTH = 24
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    i2cbr_item_if.sink                            item,
    i2cbr_res_if.source                           result,
    input  wire logic                             cfg_wr_en,
    input  wire logic [i2cbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [i2cbr_pkg::CFG_DATA_W-1:0] cfg_data
);

    i2cbr_pkg::cfg_t  cfg;
    i2cbr_pkg::res_t  step_res;
    i2cbr_pkg::item_t in_item_reg;
    i2cbr_pkg::res_t  out_item_reg;
    logic             in_valid_reg, in_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             advance;
    logic             step;

    i2cbr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cbr_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    assign advance    = !out_valid_reg || result.ready;
    assign step       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item.valid && item.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg <= item.data;
        end
        if (step)
        begin
            out_item_reg <= step_res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_item_reg;

endmodule

`default_nettype wire

[rtl/i2cbr_checker.sv]
// Port-level checks for the recovery sequencer, bound to the top level.
// Depends on i2cbr_pkg and i2c_bus_recovery_sequencer.
`default_nettype none

module i2cbr_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            res_valid,
    input  wire logic            res_ready,
    input  wire i2cbr_pkg::res_t res_data
);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.done_res) |-> !res_data.busy_res)
        else $error("result ends a sequence but reports busy");

    a_one_line_driven: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_data.scl_drive_low && res_data.sda_drive_low))
        else $error("SCL and SDA driven low together");

    a_drive_needs_pullups: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.scl_drive_low || res_data.sda_drive_low))
        |-> (res_data.pullups_on && res_data.busy_res))
        else $error("line driven low outside a running sequence");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
        else $error("stalled result dropped or changed");

endmodule

bind i2c_bus_recovery_sequencer i2cbr_checker u_i2cbr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);

`default_nettype wire
